// ===== rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants of the source line classifier: character codes,
// line classes, chunk limit and the item structures passed between stages.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int unsigned CHUNK_BYTES = 4095;
    localparam int unsigned CHUNK_W     = $clog2(CHUNK_BYTES + 1);
    localparam int unsigned TOTAL_W     = 32;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;

    typedef enum logic [1:0] {
        CLASS_BLANK   = 2'd0,
        CLASS_COMMENT = 2'd1,
        CLASS_CODE    = 2'd2
    } line_class_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        line_class_t        line_class;
        logic [TOTAL_W-1:0] blank_total;
        logic [TOTAL_W-1:0] comment_total;
        logic [TOTAL_W-1:0] code_total;
        logic [TOTAL_W-1:0] file_total;
        logic               file_done;
    } result_t;

    typedef struct packed {
        logic advance;
        logic line_end;
    } stage_ctl_t;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/slc_in_reg.sv =====
// ----------------------------------------------------------------------------
// slc_in_reg
// Input register: holds one accepted byte until the classifier stage takes it.
// ----------------------------------------------------------------------------
module slc_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  slc_pkg::in_item_t in_item,
    input  logic              advance,
    output logic              item_valid,
    output slc_pkg::in_item_t item
);
    import slc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tvalid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/slc_line_core.sv =====
// ----------------------------------------------------------------------------
// slc_line_core
// Line state and totals: tracks leading characters, block comment markers and
// chunk length, classifies a finished line and updates saturating totals.
// ----------------------------------------------------------------------------
module slc_line_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slc_pkg::in_item_t    item,
    input  logic                 advance,
    output slc_pkg::stage_ctl_t  ctl,
    output slc_pkg::result_t     result
);
    import slc_pkg::*;

    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_ONE  = 2'd1,
        LEAD_TWO  = 2'd2
    } lead_t;

    logic               block_open_reg,    block_open_next;
    logic               still_leading_reg, still_leading_next;
    lead_t              lead_seen_reg,     lead_seen_next;
    logic [7:0]         first_char_reg,    first_char_next;
    logic [7:0]         second_char_reg,   second_char_next;
    logic               prev_star_reg,     prev_star_next;
    logic               close_seen_reg,    close_seen_next;
    logic [CHUNK_W-1:0] chunk_length_reg,  chunk_length_next;
    logic [TOTAL_W-1:0] file_count_reg,    file_count_next;
    logic [TOTAL_W-1:0] blank_count_reg,   blank_count_next;
    logic [TOTAL_W-1:0] comment_count_reg, comment_count_next;
    logic [TOTAL_W-1:0] code_count_reg,    code_count_next;

    logic        is_space;
    logic        is_newline;
    logic        line_end;
    line_class_t cls;

    always_comb
    begin
        is_space   = (item.byte_value == CHAR_SPACE) || (item.byte_value == CHAR_TAB);
        is_newline = (item.byte_value == CHAR_NEWLINE);

        block_open_next    = block_open_reg;
        still_leading_next = still_leading_reg;
        lead_seen_next     = lead_seen_reg;
        first_char_next    = first_char_reg;
        second_char_next   = second_char_reg;
        file_count_next    = file_count_reg;
        blank_count_next   = blank_count_reg;
        comment_count_next = comment_count_reg;
        code_count_next    = code_count_reg;
        chunk_length_next  = chunk_length_reg + 1'b1;

        if (!(still_leading_reg && (is_space || is_newline)))
        begin
            still_leading_next = 1'b0;
            if (lead_seen_reg == LEAD_NONE)
            begin
                first_char_next = item.byte_value;
                lead_seen_next  = LEAD_ONE;
            end
            else if ((lead_seen_reg == LEAD_ONE) && !is_newline)
            begin
                second_char_next = item.byte_value;
                lead_seen_next   = LEAD_TWO;
            end
        end

        close_seen_next = close_seen_reg
                          || (prev_star_reg && (item.byte_value == CHAR_SLASH));
        prev_star_next  = (item.byte_value == CHAR_STAR);

        line_end = is_newline || item.end_of_file
                   || (chunk_length_next >= CHUNK_W'(CHUNK_BYTES));

        cls = CLASS_CODE;
        if (lead_seen_next == LEAD_NONE)
        begin
            cls = CLASS_BLANK;
        end
        else if (block_open_reg)
        begin
            cls = CLASS_COMMENT;
            if (close_seen_next)
            begin
                block_open_next = 1'b0;
            end
        end
        else if ((lead_seen_next == LEAD_TWO) && (first_char_next == CHAR_SLASH)
                 && (second_char_next == CHAR_SLASH))
        begin
            cls = CLASS_COMMENT;
        end
        else if ((lead_seen_next == LEAD_TWO) && (first_char_next == CHAR_SLASH)
                 && (second_char_next == CHAR_STAR))
        begin
            cls = CLASS_COMMENT;
            if (!close_seen_next)
            begin
                block_open_next = 1'b1;
            end
        end

        if (line_end)
        begin
            case (cls)
                CLASS_BLANK:   blank_count_next   = sat_inc(blank_count_reg);
                CLASS_COMMENT: comment_count_next = sat_inc(comment_count_reg);
                default:       code_count_next    = sat_inc(code_count_reg);
            endcase
            still_leading_next = 1'b1;
            lead_seen_next     = LEAD_NONE;
            first_char_next    = '0;
            second_char_next   = '0;
            prev_star_next     = 1'b0;
            close_seen_next    = 1'b0;
            chunk_length_next  = '0;
            if (item.end_of_file)
            begin
                file_count_next = sat_inc(file_count_reg);
                block_open_next = 1'b0;
            end
        end
        else
        begin
            block_open_next = block_open_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_open_reg    <= 1'b0;
            still_leading_reg <= 1'b1;
            lead_seen_reg     <= LEAD_NONE;
            first_char_reg    <= '0;
            second_char_reg   <= '0;
            prev_star_reg     <= 1'b0;
            close_seen_reg    <= 1'b0;
            chunk_length_reg  <= '0;
            file_count_reg    <= '0;
            blank_count_reg   <= '0;
            comment_count_reg <= '0;
            code_count_reg    <= '0;
        end
        else if (advance)
        begin
            block_open_reg    <= block_open_next;
            still_leading_reg <= still_leading_next;
            lead_seen_reg     <= lead_seen_next;
            first_char_reg    <= first_char_next;
            second_char_reg   <= second_char_next;
            prev_star_reg     <= prev_star_next;
            close_seen_reg    <= close_seen_next;
            chunk_length_reg  <= chunk_length_next;
            file_count_reg    <= file_count_next;
            blank_count_reg   <= blank_count_next;
            comment_count_reg <= comment_count_next;
            code_count_reg    <= code_count_next;
        end
    end

    assign ctl.advance  = advance;
    assign ctl.line_end = line_end;

    assign result.line_class    = cls;
    assign result.blank_total   = blank_count_next;
    assign result.comment_total = comment_count_next;
    assign result.code_total    = code_count_next;
    assign result.file_total    = file_count_next;
    assign result.file_done     = item.end_of_file;

endmodule

// ===== rtl/slc_out_reg.sv =====
// ----------------------------------------------------------------------------
// slc_out_reg
// Result register: holds one finished line item until the sink takes it.
// ----------------------------------------------------------------------------
module slc_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  slc_pkg::stage_ctl_t ctl,
    input  slc_pkg::result_t    result_in,
    output logic                m_tvalid,
    input  logic                m_tready,
    output slc_pkg::result_t    result_out
);
    import slc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    load;
    result_t result_reg;

    assign load       = ctl.advance && ctl.line_end;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== rtl/source_line_classifier.sv =====
// ----------------------------------------------------------------------------
// source_line_classifier
// Byte-stream line classifier: sorts each text line into blank, comment or
// code and reports saturating line and file totals on every finished line.
// ----------------------------------------------------------------------------
// A result is valid on the master side once the byte that ends its line has
// passed through the input register and then the result register.
// Throughput: one byte per cycle; a result held by a low m_tready stalls
// every byte behind it until the result is taken.
// Bytes that do not end a line produce no item on the master side.
// Reset clears all line state, the block comment flag and every total.
module source_line_classifier (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic         s_tlast,   // end_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [31:0] blank_total, [63:32] comment_total,
                                    // [95:64] code_total, [127:96] file_total
    output logic [1:0]   m_tuser,   // [1:0] line_class
    output logic         m_tlast    // file_done
);
    import slc_pkg::*;

    in_item_t   in_item;
    in_item_t   item;
    logic       item_valid;
    logic       advance;
    stage_ctl_t ctl;
    result_t    core_result;
    result_t    out_result;

    assign in_item.byte_value  = s_tdata;
    assign in_item.end_of_file = s_tlast;

    assign advance = item_valid && (!m_tvalid || m_tready);

    slc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    slc_line_core u_line_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .ctl     (ctl),
        .result  (core_result)
    );

    slc_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .result_in  (core_result),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result_out (out_result)
    );

    assign m_tdata = {out_result.file_total, out_result.code_total,
                      out_result.comment_total, out_result.blank_total};
    assign m_tuser = out_result.line_class;
    assign m_tlast = out_result.file_done;

endmodule

// ===== rtl/slc_checker.sv =====
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks of the source line classifier, bound to the top level.
// ----------------------------------------------------------------------------
module slc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);
    import slc_pkg::*;

    logic               out_fire;
    logic [TOTAL_W-1:0] file_seen_reg;

    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_seen_reg <= '0;
        end
        else if (out_fire)
        begin
            file_seen_reg <= m_tdata[127:96];
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result item changed");

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == CLASS_BLANK) || (m_tuser == CLASS_COMMENT)
                     || (m_tuser == CLASS_CODE))
        else $error("line class out of range");

    a_file_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !m_tlast |-> m_tdata[127:96] == file_seen_reg)
        else $error("file total moved without end of file");

endmodule

bind source_line_classifier slc_checker u_slc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/source_line_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// source_line_classifier_tb
// Streams text bytes into the line classifier and checks each reported line
// (class, running totals, file flag) against the expected item that the directed
// table gives for it, or else against a byte-level model of the classification
// rules. A short directed table comes first, then random files with blank,
// comment, block comment, code and noise lines. Both sides idle at random.
// ----------------------------------------------------------------------------
module source_line_classifier_tb;
    import slc_pkg::*;

    localparam int DIR_N        = 28;
    localparam int RANDOM_ITEMS = 920;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SHOW_MAX     = 10;

    typedef struct packed {
        logic [7:0] b;
        logic       eof;
        logic       typed;
        result_t    want;
    } stim_t;

    typedef enum int {
        LN_BLANK,
        LN_SLASH2,
        LN_OPEN,
        LN_OVERLAP,
        LN_BODY,
        LN_CODE,
        LN_NOISE
    } line_kind_t;

    localparam stim_t DIRECTED [DIR_N] = '{
        '{8'h0A, 1'b0, 1'b1, '{CLASS_BLANK, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0}},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h09, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b1, '{CLASS_BLANK, 32'd2, 32'd0, 32'd0, 32'd0, 1'b0}},
        '{8'h2F, 1'b0, 1'b0, '0},
        '{8'h2F, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b1, '{CLASS_COMMENT, 32'd2, 32'd1, 32'd0, 32'd0, 1'b0}},
        '{8'h2F, 1'b0, 1'b0, '0},
        '{8'h2A, 1'b0, 1'b0, '0},
        '{8'h2F, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b0, '0},
        '{8'h2F, 1'b0, 1'b0, '0},
        '{8'h2A, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b0, '0},
        '{8'h61, 1'b0, 1'b0, '0},
        '{8'h2A, 1'b0, 1'b0, '0},
        '{8'h2F, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b0, '0},
        '{8'h71, 1'b1, 1'b1, '{CLASS_CODE, 32'd2, 32'd4, 32'd2, 32'd1, 1'b1}},
        '{8'h2F, 1'b0, 1'b0, '0},
        '{8'h2A, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b1, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b0, '0}
    };

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    source_line_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stim_t   byte_stream [$];
    result_t pending_lines [$];
    int      mismatches;
    int      cycle_count;
    bit      steady;
    logic    drv_typed;
    result_t drv_want;

    // line state of the classifier model
    logic        in_block;
    logic        leading;
    int          lead_cnt;
    logic [7:0]  ch0;
    logic [7:0]  ch1;
    logic        star_prev;
    logic        closed;
    int          run_len;
    logic [31:0] blanks;
    logic [31:0] comments;
    logic [31:0] codes;
    logic [31:0] files;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        stim_t s;
        s = '0;
        s.b = b;
        byte_stream.push_back(s);
    endfunction

    function automatic logic [7:0] text_char();
        int r;
        logic [7:0] b;
        r = $urandom_range(0, 9);
        case (r)
            0: b = CHAR_STAR;
            1: b = CHAR_SLASH;
            2: b = CHAR_SPACE;
            3: b = CHAR_TAB;
            4, 5, 6: b = 8'($urandom_range(8'h61, 8'h7A));
            default:
            begin
                b = 8'($urandom_range(0, 254));
                if (b >= CHAR_NEWLINE)
                    b = b + 8'd1;
            end
        endcase
        return b;
    endfunction

    function automatic void push_text(int n);
        for (int k = 0; k < n; k++)
            push_byte(text_char());
    endfunction

    function automatic void push_lead();
        int n;
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
            push_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    function automatic void push_close_maybe(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            push_byte(CHAR_STAR);
            push_byte(CHAR_SLASH);
        end
    endfunction

    function automatic void push_line(line_kind_t kind);
        int n;
        case (kind)
            LN_BLANK:
                push_lead();
            LN_SLASH2:
            begin
                push_lead();
                push_byte(CHAR_SLASH);
                push_byte(CHAR_SLASH);
                push_text($urandom_range(0, 8));
            end
            LN_OPEN:
            begin
                push_lead();
                push_byte(CHAR_SLASH);
                push_byte(CHAR_STAR);
                push_text($urandom_range(0, 6));
                push_close_maybe(25);
                push_text($urandom_range(0, 4));
            end
            LN_OVERLAP:
            begin
                push_lead();
                push_byte(CHAR_SLASH);
                push_byte(CHAR_STAR);
                push_byte(CHAR_SLASH);
                push_text($urandom_range(0, 5));
            end
            LN_BODY:
            begin
                push_text($urandom_range(0, 6));
                push_close_maybe(40);
                push_text($urandom_range(0, 4));
            end
            LN_CODE:
            begin
                push_lead();
                push_text($urandom_range(1, 10));
            end
            default:
            begin
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++)
                    push_byte(8'($urandom_range(0, 255)));
                return;
            end
        endcase
        push_byte(CHAR_NEWLINE);
    endfunction

    function automatic void build_stimulus();
        int         nlines;
        int         r;
        line_kind_t kind;
        for (int i = 0; i < DIR_N; i++)
            byte_stream.push_back(DIRECTED[i]);
        while (byte_stream.size() < DIR_N + RANDOM_ITEMS)
        begin
            nlines = $urandom_range(1, 10);
            for (int k = 0; k < nlines; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    kind = LN_BLANK;
                else if (r < 24)
                    kind = LN_SLASH2;
                else if (r < 40)
                    kind = LN_OPEN;
                else if (r < 46)
                    kind = LN_OVERLAP;
                else if (r < 60)
                    kind = LN_BODY;
                else if (r < 90)
                    kind = LN_CODE;
                else
                    kind = LN_NOISE;
                push_line(kind);
                if (kind == LN_OPEN)
                    repeat ($urandom_range(0, 3))
                        push_line(LN_BODY);
            end
            if ($urandom_range(0, 1))
                push_text($urandom_range(1, 5));
            byte_stream[byte_stream.size() - 1].eof = 1'b1;
        end
    endfunction

    task automatic classify_byte(input logic [7:0] b, input logic eof,
                                 output logic done, output result_t r);
        logic        ws;
        logic        nl;
        line_class_t cls;
        ws = (b == CHAR_SPACE) || (b == CHAR_TAB);
        nl = (b == CHAR_NEWLINE);
        done = 1'b0;
        r = '0;
        run_len++;
        if (!(leading && (ws || nl)))
        begin
            leading = 1'b0;
            if (lead_cnt == 0)
            begin
                ch0 = b;
                lead_cnt = 1;
            end
            else if (lead_cnt == 1 && !nl)
            begin
                ch1 = b;
                lead_cnt = 2;
            end
        end
        if (star_prev && b == CHAR_SLASH)
            closed = 1'b1;
        star_prev = (b == CHAR_STAR);
        if (nl || eof || run_len >= CHUNK_BYTES)
        begin
            if (lead_cnt == 0)
                cls = CLASS_BLANK;
            else if (in_block)
            begin
                cls = CLASS_COMMENT;
                if (closed)
                    in_block = 1'b0;
            end
            else if (lead_cnt == 2 && ch0 == CHAR_SLASH && ch1 == CHAR_SLASH)
                cls = CLASS_COMMENT;
            else if (lead_cnt == 2 && ch0 == CHAR_SLASH && ch1 == CHAR_STAR)
            begin
                cls = CLASS_COMMENT;
                if (!closed)
                    in_block = 1'b1;
            end
            else
                cls = CLASS_CODE;
            if (cls == CLASS_BLANK && ~&blanks)
                blanks = blanks + 32'd1;
            else if (cls == CLASS_COMMENT && ~&comments)
                comments = comments + 32'd1;
            else if (cls == CLASS_CODE && ~&codes)
                codes = codes + 32'd1;
            leading = 1'b1;
            lead_cnt = 0;
            ch0 = '0;
            ch1 = '0;
            star_prev = 1'b0;
            closed = 1'b0;
            run_len = 0;
            if (eof)
            begin
                if (~&files)
                    files = files + 32'd1;
                in_block = 1'b0;
            end
            done = 1'b1;
            r.line_class = cls;
            r.blank_total = blanks;
            r.comment_total = comments;
            r.code_total = codes;
            r.file_total = files;
            r.file_done = eof;
        end
    endtask

    always @(posedge clk)
    begin
        logic    done;
        result_t pred;
        result_t got;
        result_t want;
        logic    bad;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                classify_byte(s_tdata, s_tlast, done, pred);
                if (drv_typed)
                    pending_lines.push_back(drv_want);
                else if (done)
                    pending_lines.push_back(pred);
            end
            if (m_tvalid && m_tready)
            begin
                got.line_class = line_class_t'(m_tuser);
                got.blank_total = m_tdata[31:0];
                got.comment_total = m_tdata[63:32];
                got.code_total = m_tdata[95:64];
                got.file_total = m_tdata[127:96];
                got.file_done = m_tlast;
                if (pending_lines.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display({"unexpected line: class %0d totals %0d/%0d/%0d ",
                                  "files %0d done %0b"},
                                 got.line_class, got.blank_total, got.comment_total,
                                 got.code_total, got.file_total, got.file_done);
                end
                else
                begin
                    want = pending_lines.pop_front();
                    bad = (got.line_class !== want.line_class)
                       || (got.blank_total !== want.blank_total)
                       || (got.comment_total !== want.comment_total)
                       || (got.code_total !== want.code_total)
                       || (got.file_total !== want.file_total)
                       || (got.file_done !== want.file_done);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX)
                            $display({"line mismatch: want class %0d totals %0d/%0d/%0d ",
                                      "files %0d done %0b, got class %0d totals %0d/%0d/%0d ",
                                      "files %0d done %0b"},
                                     want.line_class, want.blank_total, want.comment_total,
                                     want.code_total, want.file_total, want.file_done,
                                     got.line_class, got.blank_total, got.comment_total,
                                     got.code_total, got.file_total, got.file_done);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    initial
    begin
        int gap;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        drv_typed = 1'b0;
        drv_want = '0;
        steady = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        in_block = 1'b0;
        leading = 1'b1;
        lead_cnt = 0;
        ch0 = '0;
        ch1 = '0;
        star_prev = 1'b0;
        closed = 1'b0;
        run_len = 0;
        blanks = '0;
        comments = '0;
        codes = '0;
        files = '0;
        build_stimulus();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int i = 0; i < byte_stream.size(); i++)
        begin
            steady = ((i / 200) % 4) == 3;
            if (i == DIR_N || i == DIR_N + RANDOM_ITEMS / 2)
                while (pending_lines.size() != 0)
                begin
                    s_tvalid <= 1'b0;
                    @(negedge clk);
                end
            gap = pick_gap();
            while (gap > 0)
            begin
                s_tvalid <= 1'b0;
                gap--;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= byte_stream[i].b;
            s_tlast <= byte_stream[i].eof;
            drv_typed <= byte_stream[i].typed;
            drv_want <= byte_stream[i].want;
            do
                @(posedge clk);
            while (!s_tready);
            @(negedge clk);
        end
        s_tvalid <= 1'b0;
        drv_typed <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
